// ===== rtl/core/partition_table_range_checker_core_macros.svh =====
// Assertion macros used by the partition table checker control RTL.
`ifndef PARTITION_TABLE_RANGE_CHECKER_CORE_MACROS_SVH
`define PARTITION_TABLE_RANGE_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define PTRC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptrc: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define PTRC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptrc: next-cycle check failed");

`endif

// ===== rtl/core/ptrc_pkg.sv =====
// Types and constants of the partition table range checker.
package ptrc_pkg;

  localparam int KIND_W = 3;
  localparam int SLOT_W = 3;
  localparam int TYPE_W = 8;
  localparam int SECT_W = 32;
  localparam int CAP_W  = 33;

  localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RAW      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADD      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_VALIDATE = 3'd5;

  localparam logic [TYPE_W-1:0] STATUS_BOOT = 8'h80;
  localparam logic [TYPE_W-1:0] STATUS_NONE = 8'h00;

  localparam logic [SECT_W:0] SECT_MAX = {1'b0, {SECT_W{1'b1}}};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic              skip_slot;
    logic [TYPE_W-1:0] part_type;
    logic [TYPE_W-1:0] status_byte;
    logic              bootable;
    logic [SECT_W-1:0] start_sector;
    logic [SECT_W-1:0] sect_len;
  } item_t;

  typedef struct packed {
    logic       success;
    logic [1:0] slot_used;
    logic       overlap_found;
    logic       table_valid;
    logic       fits_capacity;
  } result_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic vload;
    logic vscan_step;
    logic apply;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              last_j;
    logic              last_i;
    logic              out_free;
  } status_t;

endpackage

// ===== rtl/core/ptrc_if.sv =====
// Valid/ready channel interfaces for items and results.
interface ptrc_item_if;
  import ptrc_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] slot;
  logic              skip_slot;
  logic [TYPE_W-1:0] part_type;
  logic [TYPE_W-1:0] status_byte;
  logic              bootable;
  logic [SECT_W-1:0] start_sector;
  logic [SECT_W-1:0] sect_len;

  modport source (output valid, kind, slot, skip_slot, part_type, status_byte, bootable,
                  start_sector, sect_len, input ready);
  modport sink (input valid, kind, slot, skip_slot, part_type, status_byte, bootable,
                start_sector, sect_len, output ready);
endinterface

interface ptrc_result_if;
  logic       valid;
  logic       ready;
  logic       success;
  logic [1:0] slot_used;
  logic       overlap_found;
  logic       table_valid;
  logic       fits_capacity;

  modport source (output valid, success, slot_used, overlap_found, table_valid,
                  fits_capacity, input ready);
  modport sink (input valid, success, slot_used, overlap_found, table_valid,
                fits_capacity, output ready);
endinterface

// ===== rtl/core/partition_table_range_checker_core.sv =====
// Top level of the partition table range checker.
//
// Items arrive on the item channel and each one gives exactly one transfer
// on the result channel; drive_capacity is written through cfg_write_en and
// cfg_write_data, which the user must do only while the block is idle; the
// block itself does not enforce this. An item is taken while the block is
// idle, then worked on by the sequencer: clear, raw write, remove and unused
// kinds go straight to the final step, add and overlap query step through the
// table comparing one entry per cycle, and validate loads each entry and then
// compares it against every other entry.
// The result register is loaded at the same edge at which the block is ready
// again, so the next item may be transferred while the last result waits.
// If the receiver stalls, the finished item holds in its final step until
// the result register is free; no further item is taken meanwhile.
// A synchronous reset empties the table, sets drive_capacity to zero and
// drops any pending result.
module partition_table_range_checker_core #(
  parameter int ENTRIES = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [ptrc_pkg::CAP_W-1:0] cfg_write_data,
  ptrc_item_if.sink                  item,
  ptrc_result_if.source              result
);
  import ptrc_pkg::*;

  item_t   item_data;
  cmd_t    cmd;
  status_t sts;
  result_t res;
  logic    ready;
  logic    out_valid;

  assign item_data.kind         = item.kind;
  assign item_data.slot         = item.slot;
  assign item_data.skip_slot    = item.skip_slot;
  assign item_data.part_type    = item.part_type;
  assign item_data.status_byte  = item.status_byte;
  assign item_data.bootable     = item.bootable;
  assign item_data.start_sector = item.start_sector;
  assign item_data.sect_len     = item.sect_len;

  ptrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_kind  (item.kind),
    .in_ready (ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptrc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item_data (item_data),
    .cfg_we    (cfg_write_en),
    .cfg_data  (cfg_write_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (result.ready),
    .out_valid (out_valid),
    .res       (res)
  );

  assign item.ready           = ready;
  assign result.valid         = out_valid;
  assign result.success       = res.success;
  assign result.slot_used     = res.slot_used;
  assign result.overlap_found = res.overlap_found;
  assign result.table_valid   = res.table_valid;
  assign result.fits_capacity = res.fits_capacity;

endmodule

// ===== rtl/core/ptrc_ctrl.sv =====
// Sequencing state machine of the partition table checker.
`include "partition_table_range_checker_core_macros.svh"

module ptrc_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [ptrc_pkg::KIND_W-1:0] in_kind,
  output logic                      in_ready,
  input  ptrc_pkg::status_t         sts,
  output ptrc_pkg::cmd_t            cmd
);
  import ptrc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_VLOAD = 3'd2;
  localparam logic [2:0] S_VSCAN = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_kind == KIND_ADD || in_kind == KIND_QUERY) begin
            state_next = S_SCAN;
          end else if (in_kind == KIND_VALIDATE) begin
            state_next = S_VLOAD;
          end else begin
            state_next = S_APPLY;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.last_j) begin
          state_next = S_APPLY;
        end
      end
      S_VLOAD: begin
        cmd.vload  = 1'b1;
        state_next = S_VSCAN;
      end
      S_VSCAN: begin
        cmd.vscan_step = 1'b1;
        if (sts.last_j) begin
          state_next = sts.last_i ? S_APPLY : S_VLOAD;
        end
      end
      S_APPLY: begin
        if (sts.out_free) begin
          cmd.apply  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `PTRC_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `PTRC_ASSERT_IMP(a_one_command, 1'b1, $onehot0(cmd))
  `PTRC_ASSERT_IMP(a_scan_kind, state == S_SCAN, sts.kind == KIND_ADD || sts.kind == KIND_QUERY)
  `PTRC_ASSERT_IMP(a_validate_kind, state == S_VLOAD || state == S_VSCAN,
                   sts.kind == KIND_VALIDATE)

endmodule

// ===== rtl/core/ptrc_datapath.sv =====
// Partition table storage, range comparison unit and result register.
module ptrc_datapath #(
  parameter int ENTRIES = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ptrc_pkg::item_t            item_data,
  input  logic                       cfg_we,
  input  logic [ptrc_pkg::CAP_W-1:0] cfg_data,
  input  ptrc_pkg::cmd_t             cmd,
  output ptrc_pkg::status_t          sts,
  input  logic                       out_ready,
  output logic                       out_valid,
  output ptrc_pkg::result_t          res
);
  import ptrc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SEL_W = (IDX_W > SLOT_W) ? IDX_W + 1 : SLOT_W + 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  function automatic logic range_bad(input logic [SECT_W-1:0] s, input logic [SECT_W-1:0] c);
    return (c == '0) || (({1'b0, s} + {1'b0, c}) > SECT_MAX);
  endfunction

  logic [TYPE_W-1:0] ent_status [ENTRIES];
  logic [TYPE_W-1:0] ent_type   [ENTRIES];
  logic [SECT_W-1:0] ent_start  [ENTRIES];
  logic [SECT_W-1:0] ent_count  [ENTRIES];

  item_t             itm;
  logic [CAP_W-1:0]  cap;
  logic [SECT_W-1:0] probe_start;
  logic [SECT_W-1:0] probe_count;
  logic              probe_skip_en;
  logic [IDX_W-1:0]  probe_skip_idx;
  logic [IDX_W-1:0]  j;
  logic [IDX_W-1:0]  i;
  logic              ovl;
  logic              empty_found;
  logic [IDX_W-1:0]  empty_idx;
  logic              valid_acc;
  logic              fit_acc;
  logic              chk_en;

  logic [IDX_W-1:0]  rd_idx;
  logic [TYPE_W-1:0] rd_status;
  logic [TYPE_W-1:0] rd_type;
  logic [SECT_W-1:0] rd_start;
  logic [SECT_W-1:0] rd_count;
  logic [SECT_W:0]   rd_end;
  logic              rd_empty;
  logic              rd_bad;
  logic [SECT_W:0]   probe_end;
  logic              hit;
  logic              ovl_next;
  logic              entry_ok;
  logic              entry_fits;
  logic [SEL_W-1:0]  slot_w;
  logic              slot_ok;
  logic [IDX_W-1:0]  slot_idx;
  logic [SEL_W-1:0]  in_slot_w;
  logic              in_slot_ok;
  logic              add_ok;
  result_t           res_next;

  always_comb begin
    rd_idx     = cmd.vload ? i : j;
    rd_status  = ent_status[rd_idx];
    rd_type    = ent_type[rd_idx];
    rd_start   = ent_start[rd_idx];
    rd_count   = ent_count[rd_idx];
    rd_end     = {1'b0, rd_start} + {1'b0, rd_count};
    rd_empty   = (rd_type == '0);
    rd_bad     = range_bad(rd_start, rd_count);
    probe_end  = {1'b0, probe_start} + {1'b0, probe_count};
    hit        = !(probe_skip_en && (j == probe_skip_idx)) && !rd_empty &&
                 (rd_bad || (({1'b0, probe_start} < rd_end) && (probe_end > {1'b0, rd_start})));
    ovl_next   = ovl || hit;
    if (rd_empty) begin
      entry_ok = (rd_status == '0) && (rd_start == '0) && (rd_count == '0);
    end else begin
      entry_ok = ((rd_status == STATUS_NONE) || (rd_status == STATUS_BOOT)) &&
                 (rd_start != '0) && !rd_bad;
    end
    entry_fits = rd_empty || !(CAP_W'(rd_end) > cap);
    slot_w     = SEL_W'(itm.slot);
    slot_ok    = slot_w < SEL_W'(ENTRIES);
    slot_idx   = slot_w[IDX_W-1:0];
    in_slot_w  = SEL_W'(item_data.slot);
    in_slot_ok = in_slot_w < SEL_W'(ENTRIES);
    add_ok     = (itm.start_sector != '0) && !ovl && empty_found;
  end

  always_comb begin
    res_next = '0;
    unique case (itm.kind)
      KIND_CLEAR: begin
        res_next.success = 1'b1;
      end
      KIND_RAW, KIND_REMOVE: begin
        res_next.success = slot_ok;
      end
      KIND_ADD: begin
        res_next.success       = add_ok;
        res_next.overlap_found = ovl;
        res_next.slot_used     = add_ok ? 2'(empty_idx) : 2'd0;
      end
      KIND_QUERY: begin
        res_next.success       = 1'b1;
        res_next.overlap_found = ovl;
      end
      KIND_VALIDATE: begin
        res_next.success       = valid_acc;
        res_next.table_valid   = valid_acc;
        res_next.fits_capacity = valid_acc && fit_acc && (cap != '0);
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cap       <= '0;
      for (int k = 0; k < ENTRIES; k++) begin
        ent_status[k] <= '0;
        ent_type[k]   <= '0;
        ent_start[k]  <= '0;
        ent_count[k]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        cap <= cfg_data;
      end
      if (cmd.apply) begin
        out_valid <= 1'b1;
        unique case (itm.kind)
          KIND_CLEAR: begin
            for (int k = 0; k < ENTRIES; k++) begin
              ent_status[k] <= '0;
              ent_type[k]   <= '0;
              ent_start[k]  <= '0;
              ent_count[k]  <= '0;
            end
          end
          KIND_RAW: begin
            if (slot_ok) begin
              ent_status[slot_idx] <= itm.status_byte;
              ent_type[slot_idx]   <= itm.part_type;
              ent_start[slot_idx]  <= itm.start_sector;
              ent_count[slot_idx]  <= itm.sect_len;
            end
          end
          KIND_ADD: begin
            if (add_ok) begin
              ent_status[empty_idx] <= itm.bootable ? STATUS_BOOT : STATUS_NONE;
              ent_type[empty_idx]   <= itm.part_type;
              ent_start[empty_idx]  <= itm.start_sector;
              ent_count[empty_idx]  <= itm.sect_len;
            end
          end
          KIND_REMOVE: begin
            if (slot_ok) begin
              ent_status[slot_idx] <= '0;
              ent_type[slot_idx]   <= '0;
              ent_start[slot_idx]  <= '0;
              ent_count[slot_idx]  <= '0;
            end
          end
          default: begin
          end
        endcase
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      itm            <= item_data;
      probe_start    <= item_data.start_sector;
      probe_count    <= item_data.sect_len;
      probe_skip_en  <= (item_data.kind == KIND_QUERY) && item_data.skip_slot && in_slot_ok;
      probe_skip_idx <= in_slot_w[IDX_W-1:0];
      ovl            <= range_bad(item_data.start_sector, item_data.sect_len);
      j              <= '0;
      i              <= '0;
      empty_found    <= 1'b0;
      empty_idx      <= '0;
      valid_acc      <= 1'b1;
      fit_acc        <= 1'b1;
      chk_en         <= 1'b0;
    end
    if (cmd.scan_step) begin
      ovl <= ovl_next;
      j   <= j + 1'b1;
      if (rd_empty && !empty_found) begin
        empty_found <= 1'b1;
        empty_idx   <= j;
      end
    end
    if (cmd.vload) begin
      valid_acc      <= valid_acc && entry_ok;
      fit_acc        <= fit_acc && entry_fits;
      chk_en         <= !rd_empty;
      probe_start    <= rd_start;
      probe_count    <= rd_count;
      probe_skip_en  <= 1'b1;
      probe_skip_idx <= i;
      ovl            <= rd_bad;
      j              <= '0;
    end
    if (cmd.vscan_step) begin
      ovl <= ovl_next;
      j   <= j + 1'b1;
      if (j == LAST) begin
        i <= i + 1'b1;
        if (chk_en && ovl_next) begin
          valid_acc <= 1'b0;
        end
      end
    end
    if (cmd.apply) begin
      res <= res_next;
    end
  end

  assign sts.kind     = itm.kind;
  assign sts.last_j   = (j == LAST);
  assign sts.last_i   = (i == LAST);
  assign sts.out_free = !out_valid || out_ready;

endmodule
